/* src/modular_exponentiation_core_assert.svh */
// Assertion macros for the modular exponentiation core.
// Used by src/modular_exponentiation_core.sv; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define MEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every clock edge after the first edge out of reset.
`define MEC_ASSERT_NXT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n || !$past(i_rst_n)) prop) \
        else $error(msg);
`else
`define MEC_ASSERT(lbl, prop, msg)
`define MEC_ASSERT_NXT(lbl, prop, msg)
`endif

`endif

/* src/mec_pkg.sv */
// Shared constants for the modular exponentiation core.
// No dependencies.
`timescale 1ns / 1ps

package mec_pkg;

    localparam int BASE_W      = 32;          // base_value field width
    localparam int EXP_FIELD_W = 31;          // exponent field width
    localparam int OUT_W       = 31;          // power_mod field width
    localparam int CFG_W       = 31;          // modulus register width
    localparam int MUL_STEPS   = BASE_W;      // shift-add steps per modular product

endpackage

/* src/modular_exponentiation_core.sv */
// Modular exponentiation core: right-to-left square and multiply.
// Depends on mec_pkg and modular_exponentiation_core_assert.svh.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------------
//  command  | in        | start, busy                 | i_base_value, i_exponent
//  result   | out       | o_valid (one-cycle strobe)  | o_power_mod
//  config   | in        | i_cfg_valid, o_cfg_ready    | i_cfg_data (modulus)
//
// One shared shift-add modular multiplier does all the work, each product followed
// by the pick state: one base reduction, one multiply per set exponent bit and one
// square per bit below the highest set one, then the result strobe; a zero exponent
// goes straight from the base reduction to the strobe.
// Synchronous active-low reset; the modulus resets to all ones.
// The result is shown for one cycle, never stalled; the next command is taken then.
`timescale 1ns / 1ps

`include "modular_exponentiation_core_assert.svh"

module modular_exponentiation_core
    import mec_pkg::*;
#(
    parameter int MOD_BITS = 31,
    parameter int EXP_BITS = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [BASE_W-1:0]      i_base_value,
    input  logic [EXP_FIELD_W-1:0] i_exponent,
    output logic                   o_valid,
    output logic [OUT_W-1:0]       o_power_mod,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int EXP_W = (EXP_BITS < EXP_FIELD_W) ? EXP_BITS : EXP_FIELD_W;
    localparam int CNT_W = $clog2(MUL_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,     // base mod modulus
        S_PICK,    // choose next product or finish
        S_MACC,    // acc * sq
        S_MSQ      // sq * sq
    } t_state;

    t_state               r_state;
    logic [MOD_BITS-1:0]  r_mod;
    logic [MOD_BITS-1:0]  r_acc;
    logic [MOD_BITS-1:0]  r_sq;
    logic [EXP_W-1:0]     r_exp;
    logic [MOD_BITS-1:0]  r_ma;      // multiplicand
    logic [BASE_W-1:0]    r_mb;      // multiplier, scanned MSB first
    logic [MOD_BITS-1:0]  r_mr;      // partial remainder
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_valid;
    logic [OUT_W-1:0]     r_out;

    // shared modular multiplier step: r = 2r mod m, then r = r + a mod m if bit set
    logic [MOD_BITS:0]    n_dbl;
    logic [MOD_BITS:0]    n_dbl_red;
    logic [MOD_BITS:0]    n_add;
    logic [MOD_BITS-1:0]  n_mr;
    logic [MOD_BITS-1:0]  w_cfg_mod;
    logic                 w_mul_run;

    always_comb begin
        n_dbl     = {r_mr, 1'b0};
        n_dbl_red = (n_dbl >= {1'b0, r_mod}) ? (n_dbl - {1'b0, r_mod}) : n_dbl;
        n_add     = r_mb[BASE_W-1] ? (n_dbl_red + {1'b0, r_ma}) : n_dbl_red;
        n_mr      = (n_add >= {1'b0, r_mod}) ? MOD_BITS'(n_add - {1'b0, r_mod})
                                               : n_add[MOD_BITS-1:0];
    end

    assign w_cfg_mod   = i_cfg_data[MOD_BITS-1:0];
    assign w_mul_run   = (r_state == S_RED) || (r_state == S_MACC) || (r_state == S_MSQ);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_valid;
    assign o_power_mod = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= '1;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_PICK) && (r_exp == '0);
            if (i_cfg_valid && o_cfg_ready && (w_cfg_mod != '0)) begin
                r_mod <= w_cfg_mod;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_exp   <= i_exponent[EXP_W-1:0];
                        r_acc   <= MOD_BITS'(1);
                        r_ma    <= MOD_BITS'(1);
                        r_mb    <= i_base_value;
                        r_mr    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_RED;
                    end
                end
                S_RED, S_MACC, S_MSQ: begin
                    r_mr  <= n_mr;
                    r_mb  <= {r_mb[BASE_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_PICK;
                        if (r_state == S_MACC) begin
                            r_acc    <= n_mr;
                            r_exp[0] <= 1'b0;
                        end else if (r_state == S_MSQ) begin
                            r_sq  <= n_mr;
                            r_exp <= r_exp >> 1;
                        end else begin
                            r_sq <= n_mr;
                        end
                    end
                end
                S_PICK: begin
                    r_mr  <= '0;
                    r_cnt <= '0;
                    if (r_exp == '0) begin
                        r_out   <= OUT_W'(r_acc);
                        r_state <= S_IDLE;
                    end else if (r_exp[0]) begin
                        r_ma    <= r_acc;
                        r_mb    <= BASE_W'(r_sq);
                        r_state <= S_MACC;
                    end else begin
                        r_ma    <= r_sq;
                        r_mb    <= BASE_W'(r_sq);
                        r_state <= S_MSQ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MEC_ASSERT(a_valid_idle, o_valid |-> !busy, "result strobe while busy")
    `MEC_ASSERT(a_start_busy, (start && !busy) |=> busy, "command beat not taken")
    `MEC_ASSERT_NXT(a_mod_nonzero, r_mod != '0, "modulus register is zero")
    `MEC_ASSERT_NXT(a_rem_below_mod, w_mul_run |-> (r_mr < r_mod), "remainder not reduced")
    `MEC_ASSERT_NXT(a_result_range, o_valid |-> ((o_power_mod < OUT_W'(r_mod)) || (o_power_mod == OUT_W'(1))), "result out of range")

endmodule
